[rtl/assert_macros.svh]
// assertion macros shared by the rtl of the baro sensor compensation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define BSC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define BSC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSC_ASSERT(label, prop, msg)
`define BSC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/bsc_pkg.sv]
// types, constants and saturating helpers of the baro sensor compensation block
`default_nettype none
package bsc_pkg;

	typedef logic signed [127:0] wide_t;

	localparam wide_t WIDE_MAX = {1'b0, {127{1'b1}}};
	localparam wide_t WIDE_MIN = {1'b1, {127{1'b0}}};

	localparam logic signed [31:0] I32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] I32_MIN = 32'sh8000_0000;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 54;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_COEFFS   = 3'd0,
		REG_PRES_COEFFS_A = 3'd1,
		REG_PRES_COEFFS_B = 3'd2,
		REG_PRES_COEFFS_C = 3'd3,
		REG_PRES_COEFFS_D = 3'd4,
		REG_OFFSET_SHIFTS = 3'd5
	} cfg_idx_t;

	// polynomial constants
	localparam int ZBT_BIAS  = 32768;
	localparam int ZB_BIAS   = 2048;
	localparam int Z_BIAS    = 8388608;
	localparam int TEMP_GAIN = 19000;
	localparam int TEMP_OFS  = 4000;
	localparam logic signed [21:0] PRES_GAIN = 22'sd800000;
	// 230000 * 2^24
	localparam logic signed [42:0] PRES_BIAS = 43'sd3858759680000;
	// ceil(2^35 / 9), exact floor division by 9 for values below 2^33
	localparam logic [31:0] DIV9_MAGIC = 32'd3817748708;
	localparam int DIV9_SH = 35;

	function automatic wide_t sat_add(input wide_t a, input wide_t b);
		wide_t s;
		s = a + b;
		if (a[127] == b[127] && s[127] != a[127])
			s = a[127] ? WIDE_MIN : WIDE_MAX;
		return s;
	endfunction

	function automatic wide_t sat_sub(input wide_t a, input wide_t b);
		wide_t s;
		s = a - b;
		if (a[127] != b[127] && s[127] != a[127])
			s = a[127] ? WIDE_MIN : WIDE_MAX;
		return s;
	endfunction

	function automatic logic [127:0] mag128(input wide_t x);
		logic [127:0] u;
		u = x;
		if (x[127])
			u = ~u + 128'd1;
		return u;
	endfunction

	// q is the magnitude already shifted down to an integer
	function automatic logic signed [31:0] to_i32(input logic neg, input logic [127:0] q);
		logic signed [31:0] r;
		r = q[31:0];
		if (q[127:32] != '0 || (neg ? (q[31:0] > 32'h8000_0000) : q[31]))
			r = neg ? I32_MIN : I32_MAX;
		else if (neg)
			r = -r;
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/bsc_delay.sv]
// payload delay line that advances with the pipeline
`default_nettype none
module bsc_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int i = 1; i < DEPTH; i++)
				tap_s[i] <= tap_s[i-1];
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule
`default_nettype wire

[rtl/bsc_smul.sv]
// five stage saturating fixed point multiply, a*b/2^SH truncated toward zero
`default_nettype none
module bsc_smul import bsc_pkg::*; #(
	parameter int NA = 4,
	parameter int NB = 4,
	parameter int SH = 0
) (
	input  logic  clk,
	input  logic  en,
	input  wide_t a,
	input  wide_t b,
	output wide_t y
);

	localparam int AW = 32 * NA;
	localparam int BW = 32 * NB;
	localparam int RW = BW + 32;
	localparam int PW = AW + BW;

	logic          neg_s1, neg_s2, neg_s3, neg_s4;
	logic [AW-1:0] ma_s1;
	logic [BW-1:0] mb_s1;
	logic [63:0]   pp_s2 [NA][NB];
	logic [RW-1:0] row_s3 [NA];
	logic [PW-1:0] prod_s4;
	wide_t         y_s5;

	logic [127:0]  ua, ub;
	logic [RW-1:0] row_n [NA];
	logic [PW-1:0] prod_n;
	logic [255:0]  qv;
	logic          over;
	wide_t         y_n;

	always_comb begin
		ua = mag128(a);
		ub = mag128(b);
	end

	// partial product rows
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_n[i] = '0;
			for (int j = 0; j < NB; j++)
				row_n[i] = row_n[i] + (RW'(pp_s2[i][j]) << (32 * j));
		end
	end

	always_comb begin
		prod_n = '0;
		for (int i = 0; i < NA; i++)
			prod_n = prod_n + (PW'(row_s3[i]) << (32 * i));
	end

	// shift, range check against the 128-bit limits, restore sign
	always_comb begin
		qv = 256'(prod_s4) >> SH;
		over = (qv[255:128] != '0) || (qv[127] && ((qv[126:0] != '0) || !neg_s4));
		if (over)
			y_n = neg_s4 ? WIDE_MIN : WIDE_MAX;
		else if (neg_s4)
			y_n = -wide_t'(qv[127:0]);
		else
			y_n = wide_t'(qv[127:0]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[127] ^ b[127];
			ma_s1  <= ua[AW-1:0];
			mb_s1  <= ub[BW-1:0];
			neg_s2 <= neg_s1;
			for (int i = 0; i < NA; i++)
				for (int j = 0; j < NB; j++)
					pp_s2[i][j] <= 64'(ma_s1[32*i +: 32]) * 64'(mb_s1[32*j +: 32]);
			neg_s3 <= neg_s2;
			row_s3 <= row_n;
			neg_s4 <= neg_s3;
			prod_s4 <= prod_n;
			y_s5 <= y_n;
		end
	end

	assign y = y_s5;

endmodule
`default_nettype wire

[rtl/baro_sensor_compensation.sv]
// top level of the baro sensor compensation pipeline
`default_nettype none
`include "assert_macros.svh"
// Barometric sensor compensation. Each input transaction carries a raw temperature
// conversion (bits 23..8 used as a signed 16-bit value) and a raw pressure conversion;
// each output transaction carries the compensated pressure in pascals and the
// temperature in hundredths of a degree Celsius, both saturated to 32 bits. All
// intermediates are 128-bit saturating signed fixed point with FRAC_BITS fraction
// bits. The block takes one transaction every cycle while no held result is stalled at
// the output; a result passes through 58 register stages after the edge that accepts
// its transaction, a depth set by the chain of eight dependent multiplies on the pressure
// path (five register stages each) plus the final scaling stages. When the output
// register holds a result and out_stall is high, the whole pipeline freezes and
// in_stall rises; nothing is dropped or repeated. Coefficient registers must be written
// through the cfg port only while the pipeline is empty; the block does not enforce it.
module baro_sensor_compensation import bsc_pkg::*; #(
	parameter int FRAC_BITS = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [23:0]      raw_temperature,
	input  logic signed [23:0]      raw_pressure,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [31:0]      pressure_pa,
	output logic signed [31:0]      temperature_centideg
);

	localparam int LAT = 58;

	// magnitude chunk counts of each multiply operand, from the value bounds
	localparam int N_ZBT = (FRAC_BITS + 21 + 31) / 32;
	localparam int N_U   = (FRAC_BITS + 4 + 31) / 32;
	localparam int N_ZB  = (FRAC_BITS + 23 + 31) / 32;
	localparam int N_A1  = (FRAC_BITS + 1 + 31) / 32;
	localparam int N_B1  = (FRAC_BITS + 25 + 31) / 32;
	localparam int N_K1  = (FRAC_BITS + 25 + 31) / 32;
	localparam int N_K2  = (FRAC_BITS + 49 + 31) / 32;
	localparam int N_M   = (FRAC_BITS + 74 + 31) / 32;
	localparam int N_P1  = (FRAC_BITS + 3 + 31) / 32;
	localparam int N_Z   = (FRAC_BITS + 78 + 31) / 32;
	localparam int N_W   = (FRAC_BITS + 55 + 31) / 32;
	localparam int N_TV  = (FRAC_BITS + 27 + 31) / 32;

	// p4/2^37 may land on either side of the binary point
	localparam int P4_L = (FRAC_BITS >= 37) ? FRAC_BITS - 37 : 0;
	localparam int P4_R = (FRAC_BITS >= 37) ? 0 : 37 - FRAC_BITS;

	// coefficient registers
	logic [53:0] temp_coeffs_q;
	logic [51:0] pres_coeffs_a_q, pres_coeffs_b_q, pres_coeffs_c_q;
	logic [42:0] pres_coeffs_d_q;
	logic [39:0] offset_shifts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q   <= '0;
			pres_coeffs_a_q <= '0;
			pres_coeffs_b_q <= '0;
			pres_coeffs_c_q <= '0;
			pres_coeffs_d_q <= '0;
			offset_shifts_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_TEMP_COEFFS:   temp_coeffs_q   <= cfg_data[53:0];
				REG_PRES_COEFFS_A: pres_coeffs_a_q <= cfg_data[51:0];
				REG_PRES_COEFFS_B: pres_coeffs_b_q <= cfg_data[51:0];
				REG_PRES_COEFFS_C: pres_coeffs_c_q <= cfg_data[51:0];
				REG_PRES_COEFFS_D: pres_coeffs_d_q <= cfg_data[42:0];
				REG_OFFSET_SHIFTS: offset_shifts_q <= cfg_data[39:0];
				default: ;
			endcase
		end
	end

	// coefficient fields
	logic signed [17:0] t1, t2, t3;
	logic signed [25:0] p1, p2, p3, p4, p5, p6, p7;
	logic signed [16:0] p8;
	logic        [15:0] tshift;
	logic signed [23:0] bshift;

	assign t1     = temp_coeffs_q[17:0];
	assign t2     = temp_coeffs_q[35:18];
	assign t3     = temp_coeffs_q[53:36];
	assign p1     = pres_coeffs_a_q[25:0];
	assign p2     = pres_coeffs_a_q[51:26];
	assign p3     = pres_coeffs_b_q[25:0];
	assign p4     = pres_coeffs_b_q[51:26];
	assign p5     = pres_coeffs_c_q[25:0];
	assign p6     = pres_coeffs_c_q[51:26];
	assign p7     = pres_coeffs_d_q[25:0];
	assign p8     = pres_coeffs_d_q[42:26];
	assign tshift = offset_shifts_q[15:0];
	assign bshift = offset_shifts_q[39:16];

	// fixed point forms of the coefficient ratios
	wide_t p4r, p5r, p1r, p4x;
	always_comb begin
		p4x = wide_t'(p4) <<< P4_L;
		if (p4[25])
			p4x = p4x + ((wide_t'(1) <<< P4_R) - wide_t'(1));
		p4r = p4x >>> P4_R;
		p5r = wide_t'(p5) <<< (FRAC_BITS - 12);
		p1r = wide_t'(p1) <<< (FRAC_BITS - 22);
	end

	// pipeline advance: the only hold point is the output register
	logic           adv;
	logic [LAT:1]   vld_s;

	assign adv       = !vld_s[LAT] || !out_stall;
	assign in_stall  = !adv;
	assign out_valid = vld_s[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (adv)
			vld_s <= {vld_s[LAT-1:1], in_valid};
	end

	// ---- temperature polynomial ----
	logic signed [15:0] rt;
	logic signed [18:0] rtt2_s1;
	logic signed [23:0] rp_s1;
	logic signed [36:0] tprod_s2;
	wide_t zbt_s3, zbt_s8, zbt_s13, u_s8, v_s13, tem_s14;

	assign rt = raw_temperature[23:8];

	always_ff @(posedge clk) begin
		if (adv) begin
			rtt2_s1  <= 19'(rt) + 19'(t2);
			rp_s1    <= raw_pressure;
			tprod_s2 <= 37'(t1) * 37'(rtt2_s1);
			zbt_s3   <= (wide_t'(tprod_s2) <<< (FRAC_BITS - 15))
				+ (wide_t'(ZBT_BIAS) <<< FRAC_BITS);
		end
	end

	bsc_smul #(.NA(N_ZBT), .NB(1), .SH(34)) u_mul_u (
		.clk(clk), .en(adv), .a(zbt_s3), .b(wide_t'(t3)), .y(u_s8));

	bsc_delay #(.WIDTH(128), .DEPTH(5)) u_dly_zbt_a (
		.clk(clk), .en(adv), .d(zbt_s3), .q(zbt_s8));

	bsc_smul #(.NA(N_ZBT), .NB(N_U), .SH(FRAC_BITS)) u_mul_v (
		.clk(clk), .en(adv), .a(zbt_s8), .b(u_s8), .y(v_s13));

	bsc_delay #(.WIDTH(128), .DEPTH(5)) u_dly_zbt_b (
		.clk(clk), .en(adv), .d(zbt_s8), .q(zbt_s13));

	// ---- pressure correction terms ----
	wide_t temq_s15, tsub_s15, zb_s16, zb_s22;
	wide_t a_s21, b_s21, a1_s22, b1_s22;
	wide_t k1s_s27, k2s_s27, k1_s28, k2_s28;
	wide_t temr;
	logic signed [17:0] p8b;
	logic signed [26:0] p2rp;
	logic signed [23:0] rp_s27;

	// tem / 16 rounded toward zero
	always_comb begin
		temr = tem_s14;
		if (tem_s14[127])
			temr = tem_s14 + wide_t'(15);
	end

	assign p8b  = 18'(p8) + 18'(ZB_BIAS);
	assign p2rp = 27'(p2) + 27'(rp_s27);

	always_ff @(posedge clk) begin
		if (adv) begin
			tem_s14  <= sat_add(zbt_s13, v_s13);
			temq_s15 <= temr >>> 4;
			tsub_s15 <= sat_sub(tem_s14, wide_t'(tshift) <<< FRAC_BITS);
			zb_s16   <= sat_sub(temq_s15, wide_t'(p8b) <<< FRAC_BITS);
			a1_s22   <= sat_add(a_s21, p4r);
			b1_s22   <= sat_add(b_s21, p5r);
			k1_s28   <= sat_add(k1s_s27, wide_t'(1) <<< FRAC_BITS);
			k2_s28   <= sat_add(wide_t'(p2rp) <<< FRAC_BITS, k2s_s27);
		end
	end

	bsc_smul #(.NA(N_ZB), .NB(1), .SH(48)) u_mul_a (
		.clk(clk), .en(adv), .a(zb_s16), .b(wide_t'(p6)), .y(a_s21));

	bsc_smul #(.NA(N_ZB), .NB(1), .SH(24)) u_mul_b (
		.clk(clk), .en(adv), .a(zb_s16), .b(wide_t'(p7)), .y(b_s21));

	bsc_delay #(.WIDTH(128), .DEPTH(6)) u_dly_zb (
		.clk(clk), .en(adv), .d(zb_s16), .q(zb_s22));

	bsc_smul #(.NA(N_ZB), .NB(N_A1), .SH(FRAC_BITS)) u_mul_k1 (
		.clk(clk), .en(adv), .a(zb_s22), .b(a1_s22), .y(k1s_s27));

	bsc_smul #(.NA(N_ZB), .NB(N_B1), .SH(FRAC_BITS)) u_mul_k2 (
		.clk(clk), .en(adv), .a(zb_s22), .b(b1_s22), .y(k2s_s27));

	bsc_delay #(.WIDTH(24), .DEPTH(26)) u_dly_rp (
		.clk(clk), .en(adv), .d(rp_s1), .q(rp_s27));

	// ---- pressure scaling and p3 term ----
	wide_t m_s33, n_s38, z_s39, z_s44, z_s49, w_s44, pz_s49, pf_s50;

	bsc_smul #(.NA(N_K1), .NB(N_K2), .SH(FRAC_BITS)) u_mul_m (
		.clk(clk), .en(adv), .a(k1_s28), .b(k2_s28), .y(m_s33));

	bsc_smul #(.NA(N_M), .NB(N_P1), .SH(FRAC_BITS)) u_mul_n (
		.clk(clk), .en(adv), .a(m_s33), .b(p1r), .y(n_s38));

	always_ff @(posedge clk) begin
		if (adv) begin
			z_s39  <= sat_add(n_s38, wide_t'(Z_BIAS) <<< FRAC_BITS);
			pf_s50 <= sat_add(z_s49, pz_s49);
		end
	end

	bsc_smul #(.NA(N_Z), .NB(1), .SH(48)) u_mul_w (
		.clk(clk), .en(adv), .a(z_s39), .b(wide_t'(p3)), .y(w_s44));

	bsc_delay #(.WIDTH(128), .DEPTH(5)) u_dly_z_a (
		.clk(clk), .en(adv), .d(z_s39), .q(z_s44));

	bsc_smul #(.NA(N_Z), .NB(N_W), .SH(FRAC_BITS)) u_mul_pz (
		.clk(clk), .en(adv), .a(z_s44), .b(w_s44), .y(pz_s49));

	bsc_delay #(.WIDTH(128), .DEPTH(5)) u_dly_z_b (
		.clk(clk), .en(adv), .d(z_s44), .q(z_s49));

	// ---- pressure to pascals ----
	logic               pneg_s51, nneg_s56, nneg_s57;
	logic [127:0]       pmag_s51;
	logic signed [31:0] np_s52;
	logic signed [32:0] d_s53;
	logic signed [53:0] dm_s54, num_s55;
	logic [53:0]        nmag;
	logic [27:0]        q1_s56;
	logic [59:0]        pq_s57;
	logic [31:0]        pr_abs;
	logic signed [31:0] pres_s58;

	assign nmag   = num_s55[53] ? 54'(-num_s55) : 54'(num_s55);
	assign pr_abs = 32'(pq_s57[59:DIV9_SH]);

	always_ff @(posedge clk) begin
		if (adv) begin
			pneg_s51 <= pf_s50[127];
			pmag_s51 <= mag128(pf_s50);
			np_s52   <= to_i32(pneg_s51, pmag_s51 >> FRAC_BITS);
			d_s53    <= 33'(np_s52) - 33'(bshift);
			dm_s54   <= 54'(d_s53) * 54'(PRES_GAIN);
			num_s55  <= dm_s54 + 54'(PRES_BIAS);
			// divide by 2^24 first, then by 9, both toward zero
			nneg_s56 <= num_s55[53];
			q1_s56   <= nmag[51:24];
			pq_s57   <= 60'(q1_s56) * 60'(DIV9_MAGIC);
			pres_s58 <= nneg_s57 ? -pr_abs : pr_abs;
		end
	end

	bsc_delay #(.WIDTH(1), .DEPTH(1)) u_dly_nneg (
		.clk(clk), .en(adv), .d(nneg_s56), .q(nneg_s57));

	// ---- temperature to centidegrees ----
	wide_t              tv_s20, tc1_s21;
	logic               tneg_s22;
	logic [127:0]       tmag_s22;
	logic signed [31:0] tc_s23, temp_s58;

	bsc_smul #(.NA(N_TV), .NB(1), .SH(16)) u_mul_tv (
		.clk(clk), .en(adv), .a(tsub_s15), .b(wide_t'(TEMP_GAIN)), .y(tv_s20));

	always_ff @(posedge clk) begin
		if (adv) begin
			tc1_s21  <= sat_sub(tv_s20, wide_t'(TEMP_OFS) <<< FRAC_BITS);
			tneg_s22 <= tc1_s21[127];
			tmag_s22 <= mag128(tc1_s21);
			tc_s23   <= to_i32(tneg_s22, tmag_s22 >> FRAC_BITS);
		end
	end

	bsc_delay #(.WIDTH(32), .DEPTH(LAT - 23)) u_dly_tc (
		.clk(clk), .en(adv), .d(tc_s23), .q(temp_s58));

	assign pressure_pa          = pres_s58;
	assign temperature_centideg = temp_s58;

	// stall only comes from a held result at the output
	`BSC_ASSERT_ALWAYS(a_stall_source, in_stall |-> (out_valid && out_stall), "stray in_stall")
	// a held result freezes every stage's valid bit
	`BSC_ASSERT(a_freeze, (out_valid && out_stall) |=> $stable(vld_s), "pipeline moved")
	// pressure result stays inside the range the scaling allows
	`BSC_ASSERT(a_pres_range, out_valid |-> (pressure_pa < 32'sd33554432 && pressure_pa > -32'sd33554432), "pressure range")

endmodule
`default_nettype wire
